// ===== rtl/hkl_pkg.sv =====
// Shared constants, types and helpers for the max-heap k-th largest block.
package hkl_pkg;

    // Heap sizing and key width.
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;

    // Derived widths.
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CH_W   = IDX_W + 2;
    localparam int RANK_W = 5;
    localparam int CMP_W  = (RANK_W > CNT_W) ? RANK_W : CNT_W;
    localparam int STAT_W = 2;

    // Request kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Selection codes of the shared compare unit.
    localparam logic [1:0] SEL_BASE = 2'd0;
    localparam logic [1:0] SEL_A    = 2'd1;
    localparam logic [1:0] SEL_B    = 2'd2;

    typedef logic [KEY_BITS-1:0] key_t;

    // Result of one request, handed from the core to the output register.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        key_t              found_key;
    } res_t;

endpackage

// ===== rtl/max_heap_kth_largest_top.sv =====
// Top level of the max-heap k-th largest block: stream ports and output register.
//
// The block keeps a binary max-heap of up to 16 keys. Each request on the
// slave channel is either an insert (s_tuser low) of the key in s_tdata, or a
// query (s_tuser high) for the k-th largest key, k taken from s_tdata. Every
// request gives exactly one result on the master channel: the found key and a
// status (ok, insert into a full heap dropped, or rank out of range). A
// successful query consumes the heap, which is empty afterward.
// The work runs on one shared compare unit under a small sequencer, with the
// heap in a memory that has one write port and two registered read ports.
// An insert climbs one level per read step and compare-and-write step, and
// writes the key directly when it reaches the root. A query with rank k
// removes the root k - 1 times, each removal followed by a sift-down; each
// sift-down level is one read step and one compare-and-write step. Rejected
// requests go straight to the result.
// s_tready is high only while the sequencer is idle, so one request is in work
// at a time; at the earliest, the next request is accepted in the cycle after
// a result enters the output register. While a result waits there, the next
// request is still taken and its result is held inside until the receiver
// takes the earlier one, so a stalled receiver loses nothing.
// Reset (aresetn low at a clock edge) empties the heap and drops any result.
module max_heap_kth_largest_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] key, [20:16] rank, [23:21] zero
    input  logic        s_tuser,   // [0] kind: 0 insert, 1 query
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] found_key, [17:16] status, [23:18] zero
);

    logic          core_idle;
    logic          core_res_valid;
    logic          out_free;
    logic          start;
    hkl_pkg::res_t core_res;

    logic          m_tvalid_reg, m_tvalid_next;
    hkl_pkg::res_t m_res_reg, m_res_next;

    assign s_tready = core_idle;
    assign start    = s_tvalid && core_idle;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;

    hkl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .kind      (s_tuser),
        .key_in    (s_tdata[hkl_pkg::KEY_BITS-1:0]),
        .rank_in   (s_tdata[20:16]),
        .idle      (core_idle),
        .res_valid (core_res_valid),
        .res_ready (out_free),
        .res       (core_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (out_free) begin
            m_tvalid_next = core_res_valid;
            if (core_res_valid) begin
                m_res_next = core_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_res_reg.status, m_res_reg.found_key};

endmodule

// ===== rtl/hkl_cmp.sv =====
// Shared three-way compare unit: picks the largest of a base key and two candidates.
module hkl_cmp (
    input  hkl_pkg::key_t base_key,
    input  hkl_pkg::key_t a_key,
    input  logic          a_ok,
    input  hkl_pkg::key_t b_key,
    input  logic          b_ok,
    output logic [1:0]    sel,
    output hkl_pkg::key_t best_key
);

    hkl_pkg::key_t mid_key;
    logic [1:0]    mid_sel;

    // A candidate wins only when strictly larger, so equal keys never move.
    always_comb begin
        mid_key = base_key;
        mid_sel = hkl_pkg::SEL_BASE;
        if (a_ok && (a_key > base_key)) begin
            mid_key = a_key;
            mid_sel = hkl_pkg::SEL_A;
        end
        best_key = mid_key;
        sel      = mid_sel;
        if (b_ok && (b_key > mid_key)) begin
            best_key = b_key;
            sel      = hkl_pkg::SEL_B;
        end
    end

endmodule

// ===== rtl/hkl_core.sv =====
// Heap storage and the sequencer that runs sift-up, removals and sift-down.
module hkl_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        kind,
    input  hkl_pkg::key_t               key_in,
    input  logic [hkl_pkg::RANK_W-1:0]  rank_in,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output hkl_pkg::res_t               res
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_UP_RD     = 4'd1;
    localparam logic [3:0] S_UP_CMP    = 4'd2;
    localparam logic [3:0] S_RM_RD     = 4'd3;
    localparam logic [3:0] S_RM_WAIT   = 4'd4;
    localparam logic [3:0] S_DN_RD     = 4'd5;
    localparam logic [3:0] S_DN_CMP    = 4'd6;
    localparam logic [3:0] S_ROOT_RD   = 4'd7;
    localparam logic [3:0] S_ROOT_WAIT = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    localparam int IW = hkl_pkg::IDX_W;
    localparam int NW = hkl_pkg::CNT_W;
    localparam int HW = hkl_pkg::CH_W;

    // Heap memory: one write port, two registered read ports.
    hkl_pkg::key_t heap_mem [hkl_pkg::CAPACITY];
    hkl_pkg::key_t rd_a_reg, rd_b_reg;

    logic [3:0]                  state_reg, state_next;
    logic [NW-1:0]               count_reg, count_next;
    logic [NW-1:0]               live_reg, live_next;
    logic [IW-1:0]               pos_reg, pos_next;
    logic [hkl_pkg::RANK_W-1:0]  rem_reg, rem_next;
    hkl_pkg::key_t               cur_reg, cur_next;
    hkl_pkg::res_t               res_reg, res_next;

    logic                        we;
    logic [IW-1:0]               waddr;
    hkl_pkg::key_t               wdata;
    logic [IW-1:0]               raddr_a, raddr_b;

    logic [IW-1:0]               pos_m1, parent;
    logic [HW-1:0]               left_idx, right_idx;
    logic [NW-1:0]               live_m1;
    logic                        left_ok, right_ok;
    logic                        rank_bad;

    hkl_pkg::key_t               cmp_base, cmp_a, cmp_b, cmp_best;
    logic                        cmp_a_ok, cmp_b_ok;
    logic [1:0]                  cmp_sel;

    assign pos_m1    = pos_reg - IW'(1);
    assign parent    = pos_m1 >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + HW'(1);
    assign live_m1   = live_reg - NW'(1);
    assign left_ok   = left_idx < HW'(live_reg);
    assign right_ok  = right_idx < HW'(live_reg);
    assign rank_bad  = (rank_in == '0) ||
                       (hkl_pkg::CMP_W'(rank_in) > hkl_pkg::CMP_W'(count_reg));

    // The one compare unit serves both directions. Sifting up, the moving key
    // is the candidate against its parent; sifting down, the children are
    // candidates against the moving key.
    always_comb begin
        if (state_reg == S_UP_CMP) begin
            cmp_base = rd_a_reg;
            cmp_a    = cur_reg;
            cmp_a_ok = 1'b1;
            cmp_b    = rd_b_reg;
            cmp_b_ok = 1'b0;
        end else begin
            cmp_base = cur_reg;
            cmp_a    = rd_a_reg;
            cmp_a_ok = left_ok;
            cmp_b    = rd_b_reg;
            cmp_b_ok = right_ok;
        end
    end

    hkl_cmp u_cmp (
        .base_key (cmp_base),
        .a_key    (cmp_a),
        .a_ok     (cmp_a_ok),
        .b_key    (cmp_b),
        .b_ok     (cmp_b_ok),
        .sel      (cmp_sel),
        .best_key (cmp_best)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        live_next  = live_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = cur_reg;
        raddr_a    = parent;
        raddr_b    = right_idx[IW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    res_next.found_key = '0;
                    res_next.status    = hkl_pkg::ST_OK;
                    if (kind == hkl_pkg::KIND_INSERT) begin
                        if (count_reg >= NW'(hkl_pkg::CAPACITY)) begin
                            res_next.status = hkl_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end else begin
                            cur_next   = key_in;
                            pos_next   = count_reg[IW-1:0];
                            count_next = count_reg + NW'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        if (rank_bad) begin
                            res_next.status = hkl_pkg::ST_RANGE;
                            state_next      = S_DONE;
                        end else begin
                            live_next  = count_reg;
                            rem_next   = rank_in - hkl_pkg::RANK_W'(1);
                            state_next = (rank_in == hkl_pkg::RANK_W'(1)) ?
                                         S_ROOT_RD : S_RM_RD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                raddr_a = parent;
                if (pos_reg == '0) begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    wdata      = cur_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we    = 1'b1;
                waddr = pos_reg;
                if (cmp_sel == hkl_pkg::SEL_A) begin
                    // Parent moves down into the hole; keep climbing.
                    wdata      = rd_a_reg;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end else begin
                    wdata      = cur_reg;
                    state_next = S_DONE;
                end
            end
            S_RM_RD: begin
                raddr_a    = live_m1[IW-1:0];
                state_next = S_RM_WAIT;
            end
            S_RM_WAIT: begin
                // The last live key replaces the root; the old root is dead.
                cur_next   = rd_a_reg;
                live_next  = live_m1;
                pos_next   = '0;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                raddr_a    = left_idx[IW-1:0];
                raddr_b    = right_idx[IW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                we    = 1'b1;
                waddr = pos_reg;
                wdata = cmp_best;
                unique case (cmp_sel)
                    hkl_pkg::SEL_A: begin
                        pos_next   = left_idx[IW-1:0];
                        state_next = S_DN_RD;
                    end
                    hkl_pkg::SEL_B: begin
                        pos_next   = right_idx[IW-1:0];
                        state_next = S_DN_RD;
                    end
                    default: begin
                        rem_next   = rem_reg - hkl_pkg::RANK_W'(1);
                        state_next = (rem_reg == hkl_pkg::RANK_W'(1)) ?
                                     S_ROOT_RD : S_RM_RD;
                    end
                endcase
            end
            S_ROOT_RD: begin
                raddr_a    = '0;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                res_next.found_key = rd_a_reg;
                count_next         = '0;
                state_next         = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        live_reg <= live_next;
        pos_reg  <= pos_next;
        rem_reg  <= rem_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== tb/max_heap_kth_largest_top_tb.sv =====
// Self-checking testbench for the max-heap k-th largest block.
`timescale 1ns / 100ps

module max_heap_kth_largest_top_tb;

    localparam int  RANDOM_ITEMS = 1725;
    localparam int  LONG_HOLD    = 400;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  CYCLE_LIMIT  = 1500000;
    localparam int  RANK_MAX     = (1 << hkl_pkg::RANK_W) - 1;

    // One row of the directed stimulus. Where has_exp is set, the expected
    // result is given in the row; otherwise the predictor supplies it.
    typedef struct {
        logic                       kind;
        hkl_pkg::key_t              key;
        logic [hkl_pkg::RANK_W-1:0] rank;
        bit                         has_exp;
        hkl_pkg::key_t              exp_key;
        logic [hkl_pkg::STAT_W-1:0] exp_status;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // [15:0] key, [20:16] rank, [23:21] zero
    logic        s_tuser = 1'b0;  // [0] kind: 0 insert, 1 query
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [15:0] found_key, [17:16] status, [23:18] zero

    // Predictor state: the heap as the block should hold it.
    hkl_pkg::key_t bid_heap [hkl_pkg::CAPACITY];
    int   bid_count = 0;

    // Results expected from the block, oldest first.
    hkl_pkg::res_t pending_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent = 0;

    step_t directed_steps [25] = '{
        // Queries on an empty heap are out of range.
        '{hkl_pkg::KIND_QUERY,  16'h1234, 5'd1,  1'b1, 16'h0000, hkl_pkg::ST_RANGE},
        '{hkl_pkg::KIND_QUERY,  16'hFFFF, 5'd0,  1'b1, 16'h0000, hkl_pkg::ST_RANGE},
        // Key extremes, with garbage in the unused rank field.
        '{hkl_pkg::KIND_INSERT, 16'hFFFF, 5'd31, 1'b1, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0000, 5'd0,  1'b1, 16'h0000, hkl_pkg::ST_OK},
        // Rank zero and rank above the count leave the heap alone.
        '{hkl_pkg::KIND_QUERY,  16'h0000, 5'd0,  1'b1, 16'h0000, hkl_pkg::ST_RANGE},
        '{hkl_pkg::KIND_QUERY,  16'h0000, 5'd31, 1'b1, 16'h0000, hkl_pkg::ST_RANGE},
        // Second largest of the two keys is the zero key; heap is consumed.
        '{hkl_pkg::KIND_QUERY,  16'hAAAA, 5'd2,  1'b1, 16'h0000, hkl_pkg::ST_OK},
        // Fill the heap with repeated keys and extremes.
        '{hkl_pkg::KIND_INSERT, 16'h0007, 5'd3,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0007, 5'd16, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h8000, 5'd0,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0007, 5'd31, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h7FFF, 5'd1,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'hFFFF, 5'd10, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0001, 5'd0,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h8000, 5'd21, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h5555, 5'd5,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'hAAAA, 5'd6,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0007, 5'd7,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0000, 5'd8,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'hFFFF, 5'd9,  1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h1234, 5'd11, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h8000, 5'd12, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        '{hkl_pkg::KIND_INSERT, 16'h0002, 5'd13, 1'b0, 16'h0000, hkl_pkg::ST_OK},
        // A seventeenth key is dropped by the full heap.
        '{hkl_pkg::KIND_INSERT, 16'h4321, 5'd2,  1'b1, 16'h0000, hkl_pkg::ST_FULL},
        // Deepest query: the smallest of sixteen keys.
        '{hkl_pkg::KIND_QUERY,  16'h0F0F, 5'd16, 1'b0, 16'h0000, hkl_pkg::ST_OK}
    };

    max_heap_kth_largest_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void swap_bids(int a, int b);
        hkl_pkg::key_t t;
        t = bid_heap[a];
        bid_heap[a] = bid_heap[b];
        bid_heap[b] = t;
    endfunction

    // Applies one request to the predicted heap and returns the result the
    // block must give for it. Sifting only passes strictly smaller keys.
    function automatic hkl_pkg::res_t kth_outcome(logic kind, hkl_pkg::key_t key,
                                                  logic [hkl_pkg::RANK_W-1:0] rank);
        hkl_pkg::res_t r;
        int   pos;
        int   parent;
        int   best;
        int   live;
        bit   moving;
        r.found_key = '0;
        r.status    = hkl_pkg::ST_OK;
        if (kind == hkl_pkg::KIND_INSERT) begin
            if (bid_count >= hkl_pkg::CAPACITY) begin
                r.status = hkl_pkg::ST_FULL;
            end else begin
                bid_heap[bid_count] = key;
                pos = bid_count;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (bid_heap[pos] > bid_heap[parent]) begin
                        swap_bids(pos, parent);
                        pos = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
                bid_count++;
            end
        end else if (rank == 0 || rank > bid_count) begin
            r.status = hkl_pkg::ST_RANGE;
        end else begin
            live = bid_count;
            for (int n = 1; n < rank; n++) begin
                swap_bids(0, live - 1);
                live--;
                pos = 0;
                moving = 1'b1;
                while (moving) begin
                    best = pos;
                    if (2 * pos + 1 < live && bid_heap[2 * pos + 1] > bid_heap[best])
                        best = 2 * pos + 1;
                    if (2 * pos + 2 < live && bid_heap[2 * pos + 2] > bid_heap[best])
                        best = 2 * pos + 2;
                    if (best == pos) begin
                        moving = 1'b0;
                    end else begin
                        swap_bids(pos, best);
                        pos = best;
                    end
                end
            end
            r.found_key = bid_heap[0];
            bid_count = 0;
        end
        return r;
    endfunction

    // Offers one request, after a random gap, and waits for the handshake.
    // On acceptance the expected result is queued, either the one given by
    // the caller or the predictor's.
    task automatic send_request(input logic kind, input hkl_pkg::key_t key,
                                input logic [hkl_pkg::RANK_W-1:0] rank,
                                input bit has_exp, input hkl_pkg::key_t exp_key,
                                input logic [hkl_pkg::STAT_W-1:0] exp_status);
        hkl_pkg::res_t predicted;
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, rank, key};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predicted = kth_outcome(kind, key, rank);
        if (has_exp) begin
            predicted.found_key = exp_key;
            predicted.status    = exp_status;
        end
        pending_results.push_back(predicted);
        sent++;
    endtask

    // Random key drawn so that repeats and extremes are common.
    function automatic hkl_pkg::key_t random_key();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return hkl_pkg::key_t'($urandom_range(65535));
        else if (pick < 8)
            return hkl_pkg::key_t'($urandom_range(3));
        else
            return (pick == 8) ? 16'h0000 : 16'hFFFF;
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // asks for one by bumping hold_seq. The hold is counted here so the
    // sender keeps offering requests while the block backs up.
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker: every accepted result must match the oldest expectation.
    always @(posedge aclk) begin
        hkl_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found_key=%h status=%0d", $time,
                         m_tdata[15:0], m_tdata[17:16]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.found_key) begin
                    $display("%0t: found_key mismatch: expected %h, actual %h", $time,
                             want.found_key, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[17:16] !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want.status, m_tdata[17:16]);
                    error_count++;
                end
                if (m_tdata[23:18] !== 6'd0) begin
                    $display("%0t: padding mismatch: expected 00, actual %h", $time,
                             m_tdata[23:18]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("max_heap_kth_largest_top_tb failed");
            $finish;
        end
    end

    initial begin
        int   fill;
        int   pick;
        int   phase;
        logic [hkl_pkg::RANK_W-1:0] qrank;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, no idling on either side.
        foreach (directed_steps[i])
            send_request(directed_steps[i].kind, directed_steps[i].key,
                         directed_steps[i].rank, directed_steps[i].has_exp,
                         directed_steps[i].exp_key, directed_steps[i].exp_status);

        // Random part in four idling phases: none, sender gaps, receiver
        // stalls, and both. The long receiver hold-off falls in the first.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = sent * 4 / RANDOM_ITEMS;
            case (phase)
                0: begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_gap_pct = 50;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 50;
                end
                default: begin
                    tx_gap_pct = 23;
                    rx_stall_pct = 23;
                end
            endcase
            if (sent >= 100 && hold_seq == 0)
                hold_seq = 1;

            pick = $urandom_range(99);
            if (pick < 85) begin
                // Well-formed sequence: fill the heap, then query it.
                // Now and then the fill runs past capacity.
                if (pick < 10)
                    fill = hkl_pkg::CAPACITY - bid_count + $urandom_range(1, 3);
                else
                    fill = $urandom_range(1, hkl_pkg::CAPACITY);
                repeat (fill)
                    send_request(hkl_pkg::KIND_INSERT, random_key(),
                                 hkl_pkg::RANK_W'($urandom_range(RANK_MAX)), 1'b0, '0,
                                 hkl_pkg::ST_OK);
                if ($urandom_range(99) < 80 && bid_count > 0)
                    qrank = hkl_pkg::RANK_W'($urandom_range(1, bid_count));
                else if ($urandom_range(1) == 0)
                    qrank = '0;
                else
                    qrank = hkl_pkg::RANK_W'($urandom_range(bid_count + 1, RANK_MAX));
                send_request(hkl_pkg::KIND_QUERY, hkl_pkg::key_t'($urandom_range(65535)),
                             qrank, 1'b0, '0, hkl_pkg::ST_OK);
            end else begin
                // Noise: any request the fields allow.
                send_request(logic'($urandom_range(1)),
                             hkl_pkg::key_t'($urandom_range(65535)),
                             hkl_pkg::RANK_W'($urandom_range(RANK_MAX)), 1'b0, '0,
                             hkl_pkg::ST_OK);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("max_heap_kth_largest_top_tb passed");
        else
            $display("max_heap_kth_largest_top_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hkl_pkg.sv
rtl/hkl_cmp.sv
rtl/hkl_core.sv
rtl/max_heap_kth_largest_top.sv
tb/max_heap_kth_largest_top_tb.sv
